// ----- src/dpwp_pkg.sv -----
package dpwp_pkg;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 63;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTER_X      = 4'd0,
        CFG_CENTER_Y      = 4'd1,
        CFG_RECIP_FOCAL_X = 4'd2,
        CFG_RECIP_FOCAL_Y = 4'd3,
        CFG_ROTATION_ROW0 = 4'd4,
        CFG_ROTATION_ROW1 = 4'd5,
        CFG_ROTATION_ROW2 = 4'd6,
        CFG_TRANSLATION   = 4'd7
    } cfg_idx_t;

    localparam int DEPTH_W  = 16;
    localparam int CENTER_W = 16;
    localparam int RECIP_W  = 24;
    localparam int ROT_W    = 18;
    localparam int ROW_W    = 3 * ROT_W;
    localparam int TRANS_W  = 21;
    localparam int TRANSV_W = 3 * TRANS_W;
    localparam int COLOR_W  = 24;
    localparam int WORLD_W  = 27;
    localparam int ACC_W    = 64;

    localparam logic [CENTER_W-1:0] CENTER_X_RST = 16'd5208;
    localparam logic [CENTER_W-1:0] CENTER_Y_RST = 16'd4056;
    localparam logic [RECIP_W-1:0]  RECIP_X_RST  = 24'd32388;
    localparam logic [RECIP_W-1:0]  RECIP_Y_RST  = 24'd32326;
    localparam logic [ROW_W-1:0]    ROW0_RST     = 54'd65536;
    localparam logic [ROW_W-1:0]    ROW1_RST     = 54'd17179869184;
    localparam logic [ROW_W-1:0]    ROW2_RST     = 54'd4503599627370496;
    localparam logic [TRANSV_W-1:0] TRANS_RST    = 63'd0;

    localparam logic signed [WORLD_W-1:0] WORLD_MAX = 27'sh3FFFFFF;
    localparam logic signed [WORLD_W-1:0] WORLD_MIN = 27'sh4000000;

endpackage

// ----- src/depth_pixel_to_world_point.sv -----
// Pipeline: seven register stages from the input transfer to m_tdata.
// Throughput: one pixel per clock while m_tready is high; the seven-stage
// multiply and add pipeline has no shared unit, and stalls collapse bubbles
// stage by stage.
// Reset clears all valid bits and loads the camera and pose registers with
// their default intrinsics, the identity rotation and a zero translation.
module depth_pixel_to_world_point
    import dpwp_pkg::*;
#(
    parameter int PIXEL_COORD_BITS = 12
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    // column, row, raw_depth, red_in, green_in, blue_in, zero fill
    input  logic [((2*PIXEL_COORD_BITS+DEPTH_W+COLOR_W+7)/8)*8-1:0] s_tdata,

    output logic                  m_tvalid,
    input  logic                  m_tready,
    // world_x, world_y, world_z, red_out, green_out, blue_out, zero fill
    output logic [((3*WORLD_W+COLOR_W+7)/8)*8-1:0] m_tdata,

    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int P      = PIXEL_COORD_BITS;
    localparam int M_W    = ((3*WORLD_W+COLOR_W+7)/8)*8;
    localparam int DU_W   = (P + 5 > CENTER_W + 1) ? P + 5 : CENTER_W + 1;
    localparam int M_HALF = (DEPTH_W + RECIP_W) / 2;
    localparam int PP_W   = DU_W + M_HALF + 1;
    localparam int SUM_W  = PP_W + M_HALF + 1;
    localparam int CAM_W  = SUM_W - 20;
    localparam int HI_W   = CAM_W - 24;
    localparam int LO_P_W = ROT_W + 25;
    localparam int HI_P_W = ROT_W + HI_W;
    localparam int NSTG   = 7;

    localparam logic signed [SUM_W-1:0] CAM_RND = SUM_W'(1) <<< 19;
    localparam logic signed [ACC_W-1:0] ACC_RND = ACC_W'(1) <<< 19;

    logic [CENTER_W-1:0] center_x_reg, center_y_reg;
    logic [RECIP_W-1:0]  recip_x_reg, recip_y_reg;
    logic [ROW_W-1:0]    rot_reg [3];
    logic [TRANSV_W-1:0] trans_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg <= CENTER_X_RST;
            center_y_reg <= CENTER_Y_RST;
            recip_x_reg  <= RECIP_X_RST;
            recip_y_reg  <= RECIP_Y_RST;
            rot_reg[0]   <= ROW0_RST;
            rot_reg[1]   <= ROW1_RST;
            rot_reg[2]   <= ROW2_RST;
            trans_reg    <= TRANS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CENTER_X:      center_x_reg <= cfg_data[CENTER_W-1:0];
                CFG_CENTER_Y:      center_y_reg <= cfg_data[CENTER_W-1:0];
                CFG_RECIP_FOCAL_X: recip_x_reg  <= cfg_data[RECIP_W-1:0];
                CFG_RECIP_FOCAL_Y: recip_y_reg  <= cfg_data[RECIP_W-1:0];
                CFG_ROTATION_ROW0: rot_reg[0]   <= cfg_data[ROW_W-1:0];
                CFG_ROTATION_ROW1: rot_reg[1]   <= cfg_data[ROW_W-1:0];
                CFG_ROTATION_ROW2: rot_reg[2]   <= cfg_data[ROW_W-1:0];
                CFG_TRANSLATION:   trans_reg    <= cfg_data[TRANSV_W-1:0];
                default:           ;
            endcase
        end
    end

    // A stage takes new data when it is empty or its contents move on.
    logic [NSTG:1]   vld_reg;
    logic [NSTG+1:1] stg_ready;

    always_comb
    begin
        stg_ready[NSTG+1] = m_tready;
        for (int i = NSTG; i >= 1; i--)
        begin
            stg_ready[i] = !vld_reg[i] || stg_ready[i+1];
        end
    end

    assign s_tready = stg_ready[1];
    assign m_tvalid = vld_reg[NSTG];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (stg_ready[1])
            begin
                vld_reg[1] <= s_tvalid;
            end
            for (int i = 2; i <= NSTG; i++)
            begin
                if (stg_ready[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    logic [P-1:0]       col_in, row_in;
    logic [DEPTH_W-1:0] depth_in;
    logic [COLOR_W-1:0] color_in;

    assign col_in   = s_tdata[P-1:0];
    assign row_in   = s_tdata[2*P-1:P];
    assign depth_in = s_tdata[2*P+DEPTH_W-1:2*P];
    assign color_in = s_tdata[2*P+DEPTH_W+COLOR_W-1:2*P+DEPTH_W];

    logic [COLOR_W-1:0] color_reg [NSTG];

    // Stage 1: pixel offsets and depth times reciprocal focal length.
    logic signed [DU_W-1:0]        du_reg, dv_reg, du_next, dv_next;
    logic [DEPTH_W-1:0]            d1_reg;
    logic [DEPTH_W+RECIP_W-1:0]    mx_reg, my_reg, mx_next, my_next;

    // Stage 2: offset times the split depth product.
    logic signed [PP_W-1:0]        pxl_reg, pxh_reg, pyl_reg, pyh_reg;
    logic signed [PP_W-1:0]        pxl_next, pxh_next, pyl_next, pyh_next;
    logic [DEPTH_W-1:0]            d2_reg;

    // Stage 3: camera point in 1/256 mm.
    logic signed [SUM_W-1:0]       sumx, sumy;
    logic signed [CAM_W-1:0]       cam_reg [3];
    logic signed [CAM_W-1:0]       cam_next [3];

    // Stage 4: rotation partial products; stage 5: recombined terms.
    logic signed [LO_P_W-1:0]      lo_reg [3][3];
    logic signed [HI_P_W-1:0]      hi_reg [3][3];
    logic signed [LO_P_W-1:0]      lo_next [3][3];
    logic signed [HI_P_W-1:0]      hi_next [3][3];
    logic signed [ACC_W-1:0]       term_reg [3][3];
    logic signed [ACC_W-1:0]       term_next [3][3];

    // Stage 6: world sums; stage 7: rounded and saturated outputs.
    logic signed [ACC_W-1:0]       acc_reg [3];
    logic signed [ACC_W-1:0]       acc_next [3];
    logic signed [ACC_W-21:0]      shifted [3];
    logic signed [WORLD_W-1:0]     world_reg [3];
    logic signed [WORLD_W-1:0]     world_next [3];

    always_comb
    begin
        du_next  = $signed(DU_W'({col_in, 4'b0000})) - $signed(DU_W'(center_x_reg));
        dv_next  = $signed(DU_W'({row_in, 4'b0000})) - $signed(DU_W'(center_y_reg));
        mx_next  = (DEPTH_W+RECIP_W)'(depth_in) * (DEPTH_W+RECIP_W)'(recip_x_reg);
        my_next  = (DEPTH_W+RECIP_W)'(depth_in) * (DEPTH_W+RECIP_W)'(recip_y_reg);

        pxl_next = du_reg * $signed({1'b0, mx_reg[M_HALF-1:0]});
        pxh_next = du_reg * $signed({1'b0, mx_reg[2*M_HALF-1:M_HALF]});
        pyl_next = dv_reg * $signed({1'b0, my_reg[M_HALF-1:0]});
        pyh_next = dv_reg * $signed({1'b0, my_reg[2*M_HALF-1:M_HALF]});

        sumx = (SUM_W'(pxh_reg) <<< M_HALF) + SUM_W'(pxl_reg) + CAM_RND;
        sumy = (SUM_W'(pyh_reg) <<< M_HALF) + SUM_W'(pyl_reg) + CAM_RND;
        cam_next[0] = $signed(sumx[SUM_W-1:20]);
        cam_next[1] = $signed(sumy[SUM_W-1:20]);
        cam_next[2] = $signed(CAM_W'({d2_reg, 8'b0000_0000}));

        for (int i = 0; i < 3; i++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                lo_next[i][k] = $signed(rot_reg[i][ROT_W*k +: ROT_W])
                              * $signed({1'b0, cam_reg[k][23:0]});
                hi_next[i][k] = $signed(rot_reg[i][ROT_W*k +: ROT_W])
                              * $signed(cam_reg[k][CAM_W-1:24]);
                term_next[i][k] = (ACC_W'(hi_reg[i][k]) <<< 24) + ACC_W'(lo_reg[i][k]);
            end
            acc_next[i] = term_reg[i][0] + term_reg[i][1] + term_reg[i][2]
                        + (ACC_W'($signed(trans_reg[TRANS_W*i +: TRANS_W])) <<< 24)
                        + ACC_RND;
            shifted[i] = $signed(acc_reg[i][ACC_W-1:20]);
            if ((&shifted[i][ACC_W-21:WORLD_W-1]) || !(|shifted[i][ACC_W-21:WORLD_W-1]))
            begin
                world_next[i] = shifted[i][WORLD_W-1:0];
            end
            else if (shifted[i][ACC_W-21])
            begin
                world_next[i] = WORLD_MIN;
            end
            else
            begin
                world_next[i] = WORLD_MAX;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (stg_ready[1])
        begin
            du_reg       <= du_next;
            dv_reg       <= dv_next;
            d1_reg       <= depth_in;
            mx_reg       <= mx_next;
            my_reg       <= my_next;
            color_reg[0] <= color_in;
        end
        if (stg_ready[2])
        begin
            pxl_reg      <= pxl_next;
            pxh_reg      <= pxh_next;
            pyl_reg      <= pyl_next;
            pyh_reg      <= pyh_next;
            d2_reg       <= d1_reg;
            color_reg[1] <= color_reg[0];
        end
        if (stg_ready[3])
        begin
            cam_reg      <= cam_next;
            color_reg[2] <= color_reg[1];
        end
        if (stg_ready[4])
        begin
            lo_reg       <= lo_next;
            hi_reg       <= hi_next;
            color_reg[3] <= color_reg[2];
        end
        if (stg_ready[5])
        begin
            term_reg     <= term_next;
            color_reg[4] <= color_reg[3];
        end
        if (stg_ready[6])
        begin
            acc_reg      <= acc_next;
            color_reg[5] <= color_reg[4];
        end
        if (stg_ready[7])
        begin
            world_reg    <= world_next;
            color_reg[6] <= color_reg[5];
        end
    end

    assign m_tdata = M_W'({color_reg[NSTG-1], world_reg[2], world_reg[1], world_reg[0]});

endmodule
